// ===== rtl/led_mode_controller_defines.svh =====
// assertion macros shared by the led mode controller rtl
`ifndef LED_MODE_CONTROLLER_DEFINES_SVH
`define LED_MODE_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmc check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define LMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmc check failed");

`endif

// ===== rtl/lmc_pkg.sv =====
// types, constants and codes of the led mode controller
package lmc_pkg;

    localparam int NUM_LEDS   = 8;
    localparam int DELAY_BITS = 16;
    localparam int PIN_COUNT  = 8;
    localparam int CELL_ID_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int IDX_W      = 3;
    localparam int CMP_W      = (CELL_ID_W > IDX_W) ? CELL_ID_W : IDX_W;
    localparam int IN_DELAY_W = 16;

    localparam logic [2:0] CMD_SET_MODE  = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_PULSE_END = 3'd2;
    localparam logic [2:0] CMD_SUSPEND   = 3'd3;
    localparam logic [2:0] CMD_RESUME    = 3'd4;

    typedef logic [DELAY_BITS-1:0] t_delay;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_BLINK = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SET,
        OP_TICK,
        OP_PULSE_END,
        OP_SUSPEND,
        OP_RESUME
    } t_op;

    // word handed from cell to cell
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [IDX_W-1:0] index;
        t_mode            mode;
        t_delay           delay;
        logic             start;
    } t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

endpackage

// ===== rtl/led_mode_controller.sv =====
// top level of the led mode controller: command intake, cell chain, result word
//
//   port group     dir   word contents
//   i_s_*          in    command word: tuser cmd, tdata led_index / mode / blink_delay
//   o_m_*          out   result word: pin_levels, start_pulse_timer
//   i_cfg_*        in    active_high_mask write
//
// one command at a time: it walks the cell chain one cell per cycle,
// from the head register through the NUM_LEDS cell registers to the result
// register, and the next word is taken once the fsm is back in S_IDLE
// the result register frees the input side while a word waits on o_m_tvalid
// synchronous active-low reset: all leds off and dark, mask all ones
// a finished pass that finds the result register full keeps its start flag
// and blocks the input until the output drains
`include "led_mode_controller_defines.svh"

module led_mode_controller
    import lmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // led_index[2:0], mode[4:3], blink_delay[20:5]
    input  logic [2:0]  i_s_tuser,   // cmd[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // pin_levels[7:0], start_pulse_timer[8]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    t_state                r_state, n_state;
    logic [7:0]            r_mask;
    logic                  r_susp, n_susp;
    t_word                 r_head, n_head;
    logic                  r_held;
    logic                  r_out_valid;
    logic [PIN_COUNT-1:0]  r_out_pins;
    logic                  r_out_start;
    t_word                 w_chain [NUM_LEDS+1];
    logic [NUM_LEDS-1:0]   w_lit;
    logic [NUM_LEDS-1:0]   w_chain_valid;
    logic [PIN_COUNT-1:0]  w_pins;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_done;
    logic                  w_capture;
    logic                  w_hold;
    logic                  w_cap_start;
    t_op                   w_op;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid & o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_done      = w_chain[NUM_LEDS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 8'hFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    // command decode, suspend gating
    always_comb begin
        n_susp = r_susp;
        w_op   = OP_NOP;
        unique case (i_s_tuser)
            CMD_SET_MODE:  w_op = OP_SET;
            CMD_TICK:      w_op = r_susp ? OP_NOP : OP_TICK;
            CMD_PULSE_END: w_op = r_susp ? OP_NOP : OP_PULSE_END;
            CMD_SUSPEND: begin
                if (!r_susp) begin
                    w_op   = OP_SUSPEND;
                    n_susp = 1'b1;
                end
            end
            CMD_RESUME: begin
                if (r_susp) begin
                    w_op   = OP_RESUME;
                    n_susp = 1'b0;
                end
            end
            default: w_op = OP_NOP;
        endcase
        n_head       = '0;
        n_head.valid = w_accept;
        n_head.op    = w_op;
        n_head.index = i_s_tdata[2:0];
        n_head.mode  = t_mode'(i_s_tdata[4:3]);
        n_head.delay = t_delay'(i_s_tdata[20:5]);
        n_head.start = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_susp <= 1'b0;
            r_head <= '0;
        end else begin
            if (w_accept) begin
                r_susp <= n_susp;
            end
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    genvar g;
    generate
        for (g = 0; g < NUM_LEDS; g++) begin : g_cell
            lmc_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cell_id (CELL_ID_W'(g)),
                .i_word    (w_chain[g]),
                .o_word    (w_chain[g+1]),
                .o_lit     (w_lit[g])
            );
            assign w_chain_valid[g] = w_chain[g].valid;
        end
        for (g = 0; g < PIN_COUNT; g++) begin : g_pin
            if (g < NUM_LEDS) begin : g_used
                assign w_pins[g] = w_lit[g] ? r_mask[g] : ~r_mask[g];
            end else begin : g_unused
                assign w_pins[g] = 1'b0;
            end
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_RUN;
            S_RUN: begin
                if (w_done) begin
                    n_state = w_out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_capture   = 1'b0;
        w_hold      = 1'b0;
        w_cap_start = w_chain[NUM_LEDS].start;
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_RUN: begin
                w_capture = w_done && w_out_free;
                w_hold    = w_done && !w_out_free;
            end
            S_WAIT: begin
                w_capture   = w_out_free;
                w_cap_start = r_held;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_hold) begin
                r_held <= w_chain[NUM_LEDS].start;
            end
            if (w_capture) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_out_pins  <= w_pins;
            r_out_start <= w_cap_start;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_start, r_out_pins};

    // at most one command in the chain
    `LMC_ASSERT_NOW(a_one_in_chain, 1'b1, $onehot0({w_chain_valid, w_done}))
    // an accepted command enters the chain head next cycle
    `LMC_ASSERT_NEXT(a_head_loaded, w_accept, r_head.valid)
    // a chain result never shows up while idle
    `LMC_ASSERT_NOW(a_done_not_idle, w_done, r_state == S_RUN)
    // a new result word only follows a finished chain pass
    `LMC_ASSERT_NOW(a_result_source, $rose(o_m_tvalid), $past(r_state) != S_IDLE)

endmodule

// ===== rtl/lmc_cell.sv =====
// one led cell: holds the mode state of one led and passes the word on
`include "led_mode_controller_defines.svh"

module lmc_cell
    import lmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CELL_ID_W-1:0] i_cell_id,
    input  t_word                i_word,
    output t_word                o_word,
    output logic                 o_lit
);

    t_mode  r_cur,   n_cur;
    t_mode  r_pend,  n_pend;
    t_delay r_act,   n_act;
    t_delay r_pdly,  n_pdly;
    t_delay r_count, n_count;
    logic   r_pp,    n_pp;
    logic   r_lit,   n_lit;
    t_word  r_word,  n_word;
    logic   w_fire;
    logic   w_hit;

    assign w_hit = (CMP_W'(i_word.index) == CMP_W'(i_cell_id));

    always_comb begin
        n_cur   = r_cur;
        n_pend  = r_pend;
        n_act   = r_act;
        n_pdly  = r_pdly;
        n_count = r_count;
        n_pp    = r_pp;
        n_lit   = r_lit;
        w_fire  = 1'b0;
        if (i_word.valid) begin
            unique case (i_word.op)
                OP_SET: begin
                    if (w_hit) begin
                        n_pend = i_word.mode;
                        if (i_word.mode == MODE_BLINK) begin
                            n_pdly = i_word.delay;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_cur != r_pend) begin
                        n_cur = r_pend;
                        unique case (r_pend)
                            MODE_ON:  n_lit = 1'b1;
                            MODE_OFF: n_lit = 1'b0;
                            MODE_FLASH: begin
                                n_pend = MODE_OFF;
                                n_cur  = MODE_OFF;
                                w_fire = 1'b1;
                            end
                            MODE_BLINK: begin
                                w_fire  = 1'b1;
                                n_act   = r_pdly;
                                n_count = r_pdly;
                            end
                            default: n_cur = r_pend;
                        endcase
                    end else if (r_cur == MODE_BLINK) begin
                        priority if (r_act != r_pdly) begin
                            n_act   = r_pdly;
                            n_count = r_pdly;
                            w_fire  = 1'b1;
                        end else if (r_count != '0) begin
                            n_count = r_count - t_delay'(1);
                        end else begin
                            w_fire  = 1'b1;
                            n_count = r_act;
                        end
                    end
                    if (w_fire) begin
                        n_lit = 1'b1;
                        n_pp  = 1'b1;
                    end
                end
                OP_PULSE_END: begin
                    if (r_pp) begin
                        n_pp  = 1'b0;
                        n_lit = 1'b0;
                    end
                end
                OP_SUSPEND: begin
                    if (r_cur == MODE_ON) begin
                        n_lit = 1'b0;
                    end
                end
                OP_RESUME: begin
                    if (r_cur == MODE_ON) begin
                        n_lit = 1'b1;
                    end
                end
                default: n_lit = r_lit;
            endcase
        end
        n_word       = i_word;
        n_word.start = i_word.start | w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= MODE_OFF;
            r_pend  <= MODE_OFF;
            r_act   <= '0;
            r_pdly  <= '0;
            r_count <= '0;
            r_pp    <= 1'b0;
            r_lit   <= 1'b0;
            r_word  <= '0;
        end else begin
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_act   <= n_act;
            r_pdly  <= n_pdly;
            r_count <= n_count;
            r_pp    <= n_pp;
            r_lit   <= n_lit;
            r_word  <= n_word;
        end
    end

    assign o_word = r_word;
    assign o_lit  = r_lit;

    // flash falls back to off within the same tick
    `LMC_ASSERT_NOW(a_no_flash_current, 1'b1, r_cur != MODE_FLASH)
    // countdown is always loaded from the active delay
    `LMC_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= r_act)
    // a pulse always leaves the led lit with its flag set
    `LMC_ASSERT_NEXT(a_fire_lights, i_word.valid && w_fire, r_lit && r_pp)

endmodule
